@@ design/vph_pkg.sv @@
// Shared widths, register indexes and constant tables of the vertex lighting block.
`timescale 1ns / 1ps
package vph_pkg;

    // Width of a vector component going into the normalising unit.
    localparam int VW = 42;
    // Width of a unit vector component, Q.30 with sign.
    localparam int UW = 32;
    // Register stages from a vector entering the normalising unit to its unit vector.
    localparam int UNIT_LAT = 68;
    // Largest right shift that brings a magnitude below one in Q.30.
    localparam int SH_MAX = VW - 30;
    localparam logic [30:0] ONE30 = 31'h4000_0000;
    localparam logic [15:0] CH_MAX = 16'h8000;

    typedef enum logic [2:0] {
        CFG_MV_ROW0,
        CFG_MV_ROW1,
        CFG_MV_ROW2,
        CFG_LIGHT_POS,
        CFG_AMBIENT,
        CFG_DIFFUSE,
        CFG_SPECULAR,
        CFG_SHININESS
    } cfg_idx_t;

    // Divide by 2^30, rounding toward zero.
    function automatic logic signed [36:0] trunc30(input logic signed [66:0] p);
        logic [66:0] mag;
        logic [36:0] sh;
        mag = p[66] ? 67'(-p) : 67'(p);
        sh  = 37'(mag >> 30);
        return p[66] ? -$signed(sh) : $signed(sh);
    endfunction

    // Integer square root, used only when the constant table is built.
    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] w;
        logic [63:0] r;
        logic [63:0] b;
        w = v;
        r = '0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (w >= r + b) begin
                w = w - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Factors 2^(-2^-i) in Q.30, each the floored square root of the one before.
    function automatic logic [16:1][30:0] pow_consts();
        logic [16:1][30:0] c;
        logic [63:0] p;
        p = 64'd1 << 29;
        for (int i = 1; i <= 16; i++) begin
            p = isqrt_c(p << 30);
            c[i] = 31'(p);
        end
        return c;
    endfunction

    localparam logic [16:1][30:0] POW_C = pow_consts();

endpackage

@@ design/vph_unit.sv @@
// Pipelined vector normaliser: prescale, sum of squares, square root and three dividers.
`timescale 1ns / 1ps
module vph_unit
    import vph_pkg::*;
(
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [VW-1:0] vin [3],
    output logic signed [UW-1:0] uout [3]
);

    logic [VW-1:0] mag_full [3];
    logic [VW-1:0] big;
    logic [3:0]    shamt;

    logic [29:0] ma_reg [3];
    logic        na_reg [3];
    logic [59:0] sq_reg [3];
    logic [29:0] mb_reg [3];
    logic        nb_reg [3];

    // Square root pipeline, stage 0 holds the sum of squares.
    logic [61:0] sv_reg [33];
    logic [62:0] sr_reg [33];
    logic [29:0] sm_reg [33][3];
    logic        sn_reg [33][3];

    // Divider pipeline, stage 0 holds the first partial remainder.
    logic [31:0] dr_reg [32][3];
    logic [30:0] dq_reg [32][3];
    logic        dn_reg [32][3];
    logic        db_reg [3];
    logic [31:0] dl_reg [32];
    logic        dz_reg [32];

    logic signed [UW-1:0] u_reg [3];

    // Magnitudes, largest of the three and the shift that brings it below one.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_full[i] = vin[i][VW-1] ? VW'(-vin[i]) : VW'(vin[i]);
        end
        big = mag_full[0];
        if (mag_full[1] > big) big = mag_full[1];
        if (mag_full[2] > big) big = mag_full[2];
        shamt = '0;
        for (int i = 0; i < SH_MAX; i++) begin
            if ((big >> i) >= VW'(ONE30)) shamt = 4'(i + 1);
        end
    end

    // Prescale, then square each component, then sum.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ma_reg[i] <= 30'(mag_full[i] >> shamt);
                na_reg[i] <= vin[i][VW-1];
                sq_reg[i] <= ma_reg[i] * ma_reg[i];
                mb_reg[i] <= ma_reg[i];
                nb_reg[i] <= na_reg[i];
            end
            sv_reg[0] <= 62'(sq_reg[0]) + 62'(sq_reg[1]) + 62'(sq_reg[2]);
            sr_reg[0] <= '0;
            sm_reg[0] <= mb_reg;
            sn_reg[0] <= nb_reg;
        end
    end

    // One bit of the square root, from one bit pair of the radicand, in each stage.
    for (genvar j = 1; j <= 32; j++) begin : g_sqrt
        localparam logic [63:0] RBIT = 64'd1 << (64 - 2 * j);
        logic [63:0] trial;
        assign trial = {1'b0, sr_reg[j-1]} + RBIT;
        always_ff @(posedge aclk) begin
            if (en) begin
                if ({2'b0, sv_reg[j-1]} >= trial) begin
                    sv_reg[j] <= 62'({2'b0, sv_reg[j-1]} - trial);
                    sr_reg[j] <= 63'(({1'b0, sr_reg[j-1]} >> 1) + RBIT);
                end else begin
                    sv_reg[j] <= sv_reg[j-1];
                    sr_reg[j] <= sr_reg[j-1] >> 1;
                end
                sm_reg[j] <= sm_reg[j-1];
                sn_reg[j] <= sn_reg[j-1];
            end
        end
    end

    // Load the dividers: the quotient of mag * 2^30 by the length has 31 bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr_reg[0][i] <= 32'(sm_reg[32][i] >> 1);
                db_reg[i]    <= sm_reg[32][i][0];
                dq_reg[0][i] <= '0;
                dn_reg[0][i] <= sn_reg[32][i];
            end
            dl_reg[0] <= sr_reg[32][31:0];
            dz_reg[0] <= (sr_reg[32] == '0);
        end
    end

    // One quotient bit per stage, restoring division.
    for (genvar k = 1; k <= 31; k++) begin : g_div
        logic [32:0] shr [3];
        always_comb begin
            for (int i = 0; i < 3; i++) begin
                shr[i] = {dr_reg[k-1][i], (k == 1) ? db_reg[i] : 1'b0};
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (shr[i] >= {1'b0, dl_reg[k-1]}) begin
                        dr_reg[k][i] <= 32'(shr[i] - {1'b0, dl_reg[k-1]});
                        dq_reg[k][i] <= {dq_reg[k-1][i][29:0], 1'b1};
                    end else begin
                        dr_reg[k][i] <= shr[i][31:0];
                        dq_reg[k][i] <= {dq_reg[k-1][i][29:0], 1'b0};
                    end
                end
                dn_reg[k] <= dn_reg[k-1];
                dl_reg[k] <= dl_reg[k-1];
                dz_reg[k] <= dz_reg[k-1];
            end
        end
    end

    // Restore the signs; a zero-length vector gives the zero vector.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                if (dz_reg[31]) begin
                    u_reg[i] <= '0;
                end else if (dn_reg[31][i]) begin
                    u_reg[i] <= -$signed({1'b0, dq_reg[31][i]});
                end else begin
                    u_reg[i] <= $signed({1'b0, dq_reg[31][i]});
                end
            end
        end
    end

    assign uout = u_reg;

endmodule

@@ design/vertex_phong_lighting_top.sv @@
// Top level of the vertex lighting pipeline: transform, normalise, Phong terms, colour.
`timescale 1ns / 1ps
// Phong lighting of one vertex per clock with one point light in view space. An item enters
// whenever s_tready is high; the depth is set by the four normalising units (two of them in
// series, each with a 32-stage square root and a 31-stage divider) and the 16 squaring and 16
// multiplying stages of the power unit. The whole pipeline advances together: it stops only
// while a result waits at the output and m_tready is low. Configuration is to be written
// through cfg_we, cfg_addr and cfg_wdata only while no item is in flight; the block itself
// does not enforce this.
module vertex_phong_lighting_top
    import vph_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red, green, blue
    output logic [47:0] m_tdata,
    // facing_light
    output logic        m_tuser,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [63:0] cfg_wdata
);

    localparam int LAT    = UNIT_LAT;
    localparam int TOTAL  = 45 + 2 * LAT;
    localparam int VU_DLY = 4 + LAT;
    localparam int ND_DLY = 39 + LAT;

    logic [63:0] mv_reg [3];
    logic [47:0] light_reg;
    logic [47:0] amb_reg;
    logic [47:0] dif_reg;
    logic [47:0] spc_reg;
    logic [15:0] shin_reg;

    logic             en;
    logic [TOTAL:1]   vld_reg;

    logic signed [31:0] pp_reg [3][3];
    logic signed [31:0] np_reg [3][3];
    logic signed [VW-1:0] nv_reg [3];
    logic signed [VW-1:0] lv_reg [3];
    logic signed [VW-1:0] vv_reg [3];
    logic signed [VW-1:0] rv_reg [3];
    logic signed [UW-1:0] nu [3];
    logic signed [UW-1:0] lu [3];
    logic signed [UW-1:0] vu [3];
    logic signed [UW-1:0] ru [3];

    logic signed [UW-1:0] nu_dl_reg [2][3];
    logic signed [UW-1:0] lu_dl_reg [3][3];
    logic signed [UW-1:0] vu_dl_reg [VU_DLY][3];
    logic signed [32:0]   nd_dl_reg [ND_DLY];

    logic signed [63:0] dp_reg [3];
    logic signed [32:0] ndotl_reg;
    logic signed [64:0] rp_reg [3];
    logic signed [63:0] fp_reg [3];
    logic [30:0]        x_reg;

    logic [30:0] py_reg [17];
    logic [4:0]  pk_reg [17];
    logic [15:0] pf_reg [17];
    logic        pz_reg [17];
    logic [30:0] er_reg [17];
    logic [12:0] eq_reg [17];
    logic [15:0] efr_reg [17];
    logic        ez_reg [17];
    logic [30:0] pw_reg;

    logic [47:0] gd_reg [3];
    logic [46:0] gs_reg [3];
    logic        gface_reg;
    logic [15:0] ores_reg [3];
    logic        oface_reg;

    logic signed [36:0] rdotv;
    logic [4:0]         msb;
    logic [31:0]        dn_g;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mv_reg[0] <= 64'h0000_0000_0000_0100;
            mv_reg[1] <= 64'h0000_0000_0100_0000;
            mv_reg[2] <= 64'h0000_0100_0000_0000;
            light_reg <= '0;
            amb_reg   <= '0;
            dif_reg   <= '0;
            spc_reg   <= '0;
            shin_reg  <= 16'd512;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_MV_ROW0:   mv_reg[0] <= cfg_wdata;
                CFG_MV_ROW1:   mv_reg[1] <= cfg_wdata;
                CFG_MV_ROW2:   mv_reg[2] <= cfg_wdata;
                CFG_LIGHT_POS: light_reg <= cfg_wdata[47:0];
                CFG_AMBIENT:   amb_reg   <= cfg_wdata[47:0];
                CFG_DIFFUSE:   dif_reg   <= cfg_wdata[47:0];
                CFG_SPECULAR:  spc_reg   <= cfg_wdata[47:0];
                CFG_SHININESS: shin_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves as one; valid bits travel with the items.
    assign en       = !vld_reg[TOTAL] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[TOTAL-1:1], s_tvalid};
        end
    end

    // Model-view products for the position and the normal.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    pp_reg[r][c] <= $signed(mv_reg[r][16*c +: 16])
                                    * $signed(s_tdata[16*c +: 16]);
                    np_reg[r][c] <= $signed(mv_reg[r][16*c +: 16])
                                    * $signed(s_tdata[48 + 16*c +: 16]);
                end
            end
        end
    end

    // View position, normal, light vector and view vector.
    always_ff @(posedge aclk) begin
        logic signed [VW-1:0] sp;
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                sp = (VW'($signed(mv_reg[r][63:48])) <<< 8) + VW'(pp_reg[r][0])
                     + VW'(pp_reg[r][1]) + VW'(pp_reg[r][2]);
                nv_reg[r] <= VW'(np_reg[r][0]) + VW'(np_reg[r][1]) + VW'(np_reg[r][2]);
                lv_reg[r] <= (VW'($signed(light_reg[16*r +: 16])) <<< 8) - sp;
                vv_reg[r] <= -sp;
            end
        end
    end

    vph_unit u_norm (.aclk(aclk), .en(en), .vin(nv_reg), .uout(nu));
    vph_unit u_lite (.aclk(aclk), .en(en), .vin(lv_reg), .uout(lu));
    vph_unit u_view (.aclk(aclk), .en(en), .vin(vv_reg), .uout(vu));
    vph_unit u_refl (.aclk(aclk), .en(en), .vin(rv_reg), .uout(ru));

    // Delay lines that keep operands in step with later stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            nu_dl_reg[0] <= nu;
            nu_dl_reg[1] <= nu_dl_reg[0];
            lu_dl_reg[0] <= lu;
            for (int i = 1; i < 3; i++) lu_dl_reg[i] <= lu_dl_reg[i-1];
            vu_dl_reg[0] <= vu;
            for (int i = 1; i < VU_DLY; i++) vu_dl_reg[i] <= vu_dl_reg[i-1];
            nd_dl_reg[0] <= ndotl_reg;
            for (int i = 1; i < ND_DLY; i++) nd_dl_reg[i] <= nd_dl_reg[i-1];
        end
    end

    // N.L, then the reflected vector 2(N.L)N - L.
    always_ff @(posedge aclk) begin
        logic signed [37:0] half;
        if (en) begin
            for (int c = 0; c < 3; c++) dp_reg[c] <= 64'(lu[c]) * 64'(nu[c]);
            ndotl_reg <= 33'(trunc30(67'(dp_reg[0]) + 67'(dp_reg[1]) + 67'(dp_reg[2])));
            for (int c = 0; c < 3; c++) begin
                rp_reg[c] <= 65'(ndotl_reg) * 65'(nu_dl_reg[1][c]);
                half = 38'(trunc30(67'(rp_reg[c])));
                rv_reg[c] <= VW'(half <<< 1) - VW'(lu_dl_reg[2][c]);
            end
        end
    end

    // R.V; the power input is zero unless the vertex faces the light and R.V > 0.
    assign rdotv = trunc30(67'(fp_reg[0]) + 67'(fp_reg[1]) + 67'(fp_reg[2]));

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) fp_reg[c] <= 64'(ru[c]) * 64'(vu_dl_reg[VU_DLY-1][c]);
            if (nd_dl_reg[2 + LAT] > 0 && rdotv > 0) begin
                x_reg <= (rdotv > 37'(ONE30)) ? ONE30 : rdotv[30:0];
            end else begin
                x_reg <= '0;
            end
        end
    end

    // Leading one of the power input.
    always_comb begin
        msb = '0;
        for (int i = 0; i < 31; i++) begin
            if (x_reg[i]) msb = 5'(i);
        end
    end

    // Normalise into [1,2), then sixteen squarings give the log fraction bits.
    always_ff @(posedge aclk) begin
        if (en) begin
            pk_reg[0] <= 5'd30 - msb;
            py_reg[0] <= x_reg << (5'd30 - msb);
            pf_reg[0] <= '0;
            pz_reg[0] <= (x_reg == '0);
        end
    end

    for (genvar i = 1; i <= 16; i++) begin : g_sqr
        logic [61:0] prod;
        logic [31:0] sh;
        assign prod = py_reg[i-1] * py_reg[i-1];
        assign sh   = prod[61:30];
        always_ff @(posedge aclk) begin
            if (en) begin
                py_reg[i] <= sh[31] ? sh[31:1] : sh[30:0];
                pf_reg[i] <= {pf_reg[i-1][14:0], sh[31]};
                pk_reg[i] <= pk_reg[i-1];
                pz_reg[i] <= pz_reg[i-1];
            end
        end
    end

    // Scale minus log2 by the exponent, split into shift and fraction.
    always_ff @(posedge aclk) begin
        logic [20:0] negl;
        logic [36:0] tp;
        if (en) begin
            negl = {pk_reg[16], 16'b0} - 21'(pf_reg[16]);
            tp   = negl * shin_reg;
            eq_reg[0]  <= tp[36:24];
            efr_reg[0] <= tp[23:8];
            er_reg[0]  <= ONE30;
            ez_reg[0]  <= pz_reg[16];
        end
    end

    // One fractional power of two per stage.
    for (genvar i = 1; i <= 16; i++) begin : g_exp
        logic [61:0] prod;
        assign prod = er_reg[i-1] * POW_C[i];
        always_ff @(posedge aclk) begin
            if (en) begin
                er_reg[i]  <= efr_reg[i-1][16-i] ? prod[60:30] : er_reg[i-1];
                efr_reg[i] <= efr_reg[i-1];
                eq_reg[i]  <= eq_reg[i-1];
                ez_reg[i]  <= ez_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (ez_reg[16] || eq_reg[16] > 13'd30) begin
                pw_reg <= '0;
            end else begin
                pw_reg <= er_reg[16] >> eq_reg[16];
            end
        end
    end

    // Diffuse and specular products per channel.
    assign dn_g = (nd_dl_reg[38 + LAT] > 0) ? nd_dl_reg[38 + LAT][31:0] : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                gd_reg[c] <= dif_reg[16*c +: 16] * dn_g;
                gs_reg[c] <= spc_reg[16*c +: 16] * pw_reg;
            end
            gface_reg <= (nd_dl_reg[38 + LAT] > 0);
        end
    end

    // Sum the terms and saturate each channel at one.
    always_ff @(posedge aclk) begin
        logic [50:0] acc;
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                acc = {5'b0, amb_reg[16*c +: 16], 30'b0} + 51'(gd_reg[c]) + 51'(gs_reg[c]);
                ores_reg[c] <= (acc[50:30] > 21'(CH_MAX)) ? CH_MAX : acc[45:30];
            end
            oface_reg <= gface_reg;
        end
    end

    assign m_tdata = {ores_reg[2], ores_reg[1], ores_reg[0]};
    assign m_tuser = oface_reg;

`ifndef SYNTHESIS
    // No channel exceeds one.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] <= CH_MAX && m_tdata[31:16] <= CH_MAX
                      && m_tdata[47:32] <= CH_MAX))
        else $error("output channel above saturation");

    // A vertex that does not face the light shows the ambient colour alone; the red channel is checked.
    a_amb: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |->
            (m_tdata[15:0] == ((amb_reg[15:0] > CH_MAX) ? CH_MAX : amb_reg[15:0])))
        else $error("unlit vertex differs from ambient");

    // Lighting never darkens below the ambient term, checked on the green channel.
    a_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            (m_tdata[31:16] >= ((amb_reg[31:16] > CH_MAX) ? CH_MAX : amb_reg[31:16])))
        else $error("green channel below ambient");
`endif

endmodule
